>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the slerp RTL. They expand to
// nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Assertion that is switched off while reset is asserted.
`define QS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Assertion that must also hold during reset.
`define QS_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define QS_ASSERT(lbl, clk, rst_n, prop, msg)
`define QS_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

>>> sv/qslerp_pkg.sv
// ----------------------------------------------------------------------------
// Quaternion slerp package
// Widths, constants, the CORDIC angle table and shared types.
// ----------------------------------------------------------------------------
package qslerp_pkg;

  // Field widths.
  localparam int unsigned COMP_W   = 16;
  localparam int unsigned BLEND_W  = 16;
  localparam int unsigned THR_W    = 15;

  // Internal number formats.
  localparam int unsigned ANG_BITS     = 30;
  localparam int unsigned CORDIC_STEPS = 30;
  localparam int unsigned ROOT_W       = ANG_BITS + 1;
  localparam int unsigned RAD_W        = 2 * ANG_BITS + 1;
  localparam int unsigned SQRT_STAGES  = ROOT_W;
  localparam int unsigned XW           = 34;
  localparam int unsigned ZW           = 33;
  localparam int unsigned SW           = 33;
  localparam int unsigned DIV_QBITS    = 32;
  localparam int unsigned DIV_STAGES   = DIV_QBITS + 1;
  localparam int unsigned NUM_W        = SW + ANG_BITS;
  localparam int unsigned DOT_W        = 2 * COMP_W + 2;
  localparam int unsigned PW           = COMP_W + 1;
  localparam int unsigned BLEND_SHIFT  = 15;

  localparam logic [THR_W-1:0]   THR_RESET       = 15'd16368;
  localparam logic [BLEND_W-1:0] BLEND_ONE       = 16'd32768;
  localparam logic [31:0]        CORDIC_INV_GAIN = 32'd652032874;

  // atan(2^-i) in Q30 radians, truncated.
  function automatic logic [31:0] atan_q30(input int unsigned i);
    logic [31:0] r;
    case (i)
      0:  r = 32'd843314856;
      1:  r = 32'd497837829;
      2:  r = 32'd263043836;
      3:  r = 32'd133525158;
      4:  r = 32'd67021686;
      5:  r = 32'd33543515;
      6:  r = 32'd16775850;
      7:  r = 32'd8388437;
      8:  r = 32'd4194282;
      9:  r = 32'd2097149;
      10: r = 32'd1048575;
      11: r = 32'd524287;
      12: r = 32'd262143;
      13: r = 32'd131071;
      14: r = 32'd65535;
      15: r = 32'd32767;
      16: r = 32'd16383;
      17: r = 32'd8191;
      18: r = 32'd4095;
      19: r = 32'd2047;
      20: r = 32'd1023;
      21: r = 32'd511;
      22: r = 32'd255;
      23: r = 32'd127;
      24: r = 32'd63;
      25: r = 32'd31;
      26: r = 32'd15;
      27: r = 32'd7;
      28: r = 32'd3;
      29: r = 32'd1;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

  // Per-item data that rides alongside the arithmetic units.
  typedef struct packed {
    logic [3:0][PW-1:0]     p;
    logic [3:0][COMP_W-1:0] q;
    logic [BLEND_W-1:0]     tq;
    logic                   lin;
    logic [ANG_BITS-1:0]    cosq;
    logic [ROOT_W-1:0]      s;
  } side_t;

  // One result item.
  typedef struct packed {
    logic [COMP_W-1:0] out_x;
    logic [COMP_W-1:0] out_y;
    logic [COMP_W-1:0] out_z;
    logic [COMP_W-1:0] out_w;
    logic              used_linear;
  } res_t;

endpackage

>>> sv/qslerp_if.sv
// ----------------------------------------------------------------------------
// Slerp channel interfaces
// Valid/ready channels for input items, result items and the threshold write.
// ----------------------------------------------------------------------------
interface qslerp_in_if;
  import qslerp_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [COMP_W-1:0] from_x;
  logic signed [COMP_W-1:0] from_y;
  logic signed [COMP_W-1:0] from_z;
  logic signed [COMP_W-1:0] from_w;
  logic signed [COMP_W-1:0] to_x;
  logic signed [COMP_W-1:0] to_y;
  logic signed [COMP_W-1:0] to_z;
  logic signed [COMP_W-1:0] to_w;
  logic [BLEND_W-1:0]       blend;
  modport source (output valid, from_x, from_y, from_z, from_w, to_x, to_y, to_z, to_w,
                  blend, input ready);
  modport sink (input valid, from_x, from_y, from_z, from_w, to_x, to_y, to_z, to_w,
                blend, output ready);
endinterface

interface qslerp_out_if;
  import qslerp_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [COMP_W-1:0] out_x;
  logic signed [COMP_W-1:0] out_y;
  logic signed [COMP_W-1:0] out_z;
  logic signed [COMP_W-1:0] out_w;
  logic                     used_linear;
  modport source (output valid, out_x, out_y, out_z, out_w, used_linear, input ready);
  modport sink (input valid, out_x, out_y, out_z, out_w, used_linear, output ready);
endinterface

interface qslerp_cfg_if;
  import qslerp_pkg::*;
  logic             valid;
  logic             ready;
  logic [THR_W-1:0] linear_threshold;
  modport source (output valid, linear_threshold, input ready);
  modport sink (input valid, linear_threshold, output ready);
endinterface

>>> sv/quaternion_slerp_top.sv
// ----------------------------------------------------------------------------
// Quaternion slerp top level
// Spherical linear interpolation of two Q2.14 quaternions, fully pipelined.
// ----------------------------------------------------------------------------
// One item is accepted per clock cycle while the skid stage is empty. The path
// runs through 130 register stages in the chain of bit-per-stage units: the
// dot product and cosine square (3 stages), the square root (31 stages), the
// vectoring CORDIC for the angle (30), the angle split (1), the sine CORDICs
// (30), the weight dividers (33), the weighted products (1) and the output
// register (1).
// A two-entry output register and skid stage keep one result waiting while
// input transfers continue; the pipeline only stops once both hold results
// that the sink has not taken.
// The threshold register may be written at any time the block is idle.
`include "assert_macros.svh"

module quaternion_slerp_top #(
  parameter int unsigned FRAC_BITS = 14
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  qslerp_in_if.sink          in_i,
  qslerp_out_if.source       out_o,
  qslerp_cfg_if.sink         cfg_i
);
  import qslerp_pkg::*;

  // Compare width and the shifts that bring the cosine to Q0.30.
  localparam int unsigned CW  = 2 * FRAC_BITS + 16;
  localparam int unsigned SHR = (2 * FRAC_BITS >= ANG_BITS) ? 2 * FRAC_BITS - ANG_BITS : 0;
  localparam int unsigned SHL = (2 * FRAC_BITS < ANG_BITS) ? ANG_BITS - 2 * FRAC_BITS : 0;

  // Side pipeline positions where each unit delivers.
  localparam int unsigned S_IDX    = 1 + SQRT_STAGES;
  localparam int unsigned W_IDX    = S_IDX + CORDIC_STEPS;
  localparam int unsigned A_IDX    = W_IDX + 1;
  localparam int unsigned SIN_IDX  = A_IDX + CORDIC_STEPS;
  localparam int unsigned DIV_IDX  = SIN_IDX + DIV_STAGES;
  localparam int unsigned SIDE_LEN = DIV_IDX + 1;

  localparam int unsigned PR0_W = SW + PW;
  localparam int unsigned PR1_W = SW + COMP_W;
  localparam int unsigned SUM_W = PR0_W + 1;
  localparam int unsigned RND_W = SUM_W - ANG_BITS;

  logic adv;

  // Threshold register; the write channel is always ready.
  logic [THR_W-1:0] thr_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RESET;
    end else if (cfg_i.valid) begin
      thr_q <= cfg_i.linear_threshold;
    end
  end

  // Input stage: clamp the blend factor and form the four products.
  logic signed [COMP_W-1:0]   in_p [4];
  logic signed [COMP_W-1:0]   in_q [4];
  logic signed [COMP_W-1:0]   p1_q [4];
  logic signed [COMP_W-1:0]   q1_q [4];
  logic signed [2*COMP_W-1:0] m1_q [4];
  logic [BLEND_W-1:0]         t1_q;
  logic                       v1_q;

  assign in_p[0] = in_i.from_x;
  assign in_p[1] = in_i.from_y;
  assign in_p[2] = in_i.from_z;
  assign in_p[3] = in_i.from_w;
  assign in_q[0] = in_i.to_x;
  assign in_q[1] = in_i.to_y;
  assign in_q[2] = in_i.to_z;
  assign in_q[3] = in_i.to_w;
  assign in_i.ready = adv;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) begin
        p1_q[i] <= in_p[i];
        q1_q[i] <= in_q[i];
        m1_q[i] <= in_p[i] * in_q[i];
      end
      t1_q <= (in_i.blend > BLEND_ONE) ? BLEND_ONE : in_i.blend;
    end
  end

  // Dot product, shorter arc choice, linear decision and cosine scaling.
  logic signed [DOT_W-1:0] dot;
  logic [DOT_W-2:0]        dabs;
  logic                    dneg;
  logic [CW-1:0]           dabs_w, cosq_w;
  side_t                   side_d;

  always_comb begin
    dot  = DOT_W'(m1_q[0]) + DOT_W'(m1_q[1]) + DOT_W'(m1_q[2]) + DOT_W'(m1_q[3]);
    dneg = dot[DOT_W-1];
    dabs = dneg ? (DOT_W-1)'(-dot) : (DOT_W-1)'(dot);
    dabs_w = CW'(dabs);
    cosq_w = (dabs_w >> SHR) << SHL;
    side_d = '0;
    for (int i = 0; i < 4; i++) begin
      side_d.p[i] = dneg ? PW'(-PW'(p1_q[i])) : PW'(p1_q[i]);
      side_d.q[i] = q1_q[i];
    end
    side_d.tq   = t1_q;
    side_d.lin  = (dabs_w >= (CW'(thr_q) << FRAC_BITS)) ||
                  (dabs_w >= (CW'(1) << (2 * FRAC_BITS)));
    side_d.cosq = cosq_w[ANG_BITS-1:0];
  end

  // Side pipeline with valid bits; the root joins after the square root.
  side_t               sd_q [SIDE_LEN];
  logic [SIDE_LEN-1:0] vd_q;
  logic [ROOT_W-1:0]   root;
  side_t               sd_root;

  // The item at the square root output picks up its root.
  always_comb begin
    sd_root   = sd_q[S_IDX];
    sd_root.s = root;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sd_q[0] <= side_d;
      for (int k = 1; k < SIDE_LEN; k++) begin
        if (k == S_IDX + 1) begin
          sd_q[k] <= sd_root;
        end else begin
          sd_q[k] <= sd_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      vd_q <= '0;
    end else if (adv) begin
      v1_q <= in_i.valid;
      vd_q <= {vd_q[SIDE_LEN-2:0], v1_q};
    end
  end

  // Square of the cosine, then sin w = sqrt(1 - cos^2).
  logic [2*ANG_BITS-1:0] sq_q;
  logic [RAD_W-1:0]      rad;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sq_q <= sd_q[0].cosq * sd_q[0].cosq;
    end
  end

  assign rad = (RAD_W'(1) << (2 * ANG_BITS)) - RAD_W'(sq_q);

  qslerp_isqrt u_isqrt (
    .clk_i  (clk_i),
    .en_i   (adv),
    .rad_i  (rad),
    .root_o (root)
  );

  // Angle w = atan2(sin, cos).
  logic signed [ZW-1:0] ang;

  qslerp_cordic #(.VECTORING(1'b1)) u_vec (
    .clk_i (clk_i),
    .en_i  (adv),
    .x_i   ($signed(XW'(sd_q[S_IDX].cosq))),
    .y_i   ($signed(XW'(root))),
    .z_i   ('0),
    .y_o   (),
    .z_o   (ang)
  );

  // Split the angle into t*w and (1-t)*w.
  logic [ROOT_W-1:0]           w_clamp, w_q, a1_q, a0;
  logic [ROOT_W+BLEND_W-1:0]   wt;

  assign w_clamp = ang[ZW-1] ? '0 : ang[ROOT_W-1:0];
  assign wt      = w_clamp * sd_q[W_IDX].tq;
  assign a0      = w_q - a1_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      w_q  <= w_clamp;
      a1_q <= wt[ROOT_W+BLEND_SHIFT-1:BLEND_SHIFT];
    end
  end

  // Sines of both partial angles.
  logic signed [XW-1:0] sin0, sin1;

  qslerp_cordic #(.VECTORING(1'b0)) u_sin0 (
    .clk_i (clk_i),
    .en_i  (adv),
    .x_i   ($signed(XW'(CORDIC_INV_GAIN))),
    .y_i   ('0),
    .z_i   ($signed(ZW'(a0))),
    .y_o   (sin0),
    .z_o   ()
  );

  qslerp_cordic #(.VECTORING(1'b0)) u_sin1 (
    .clk_i (clk_i),
    .en_i  (adv),
    .x_i   ($signed(XW'(CORDIC_INV_GAIN))),
    .y_i   ('0),
    .z_i   ($signed(ZW'(a1_q))),
    .y_o   (sin1),
    .z_o   ()
  );

  // Weights sin(.)/sin w.
  logic signed [SW-1:0] dw0, dw1;

  qslerp_div u_div0 (
    .clk_i (clk_i),
    .en_i  (adv),
    .sn_i  ($signed(sin0[SW-1:0])),
    .s_i   (sd_q[SIN_IDX].s),
    .wq_o  (dw0)
  );

  qslerp_div u_div1 (
    .clk_i (clk_i),
    .en_i  (adv),
    .sn_i  ($signed(sin1[SW-1:0])),
    .s_i   (sd_q[SIN_IDX].s),
    .wq_o  (dw1)
  );

  // Weight selection and the weighted products.
  side_t                   fin;
  logic signed [SW-1:0]    w0, w1;
  logic signed [PR0_W-1:0] pr0_q [4];
  logic signed [PR1_W-1:0] pr1_q [4];
  logic                    plin_q, pv_q;

  assign fin = sd_q[DIV_IDX];
  assign w0  = fin.lin ? $signed(SW'({BLEND_ONE - fin.tq, {BLEND_SHIFT{1'b0}}})) : dw0;
  assign w1  = fin.lin ? $signed(SW'({fin.tq, {BLEND_SHIFT{1'b0}}})) : dw1;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) begin
        pr0_q[i] <= w0 * $signed(fin.p[i]);
        pr1_q[i] <= w1 * $signed(fin.q[i]);
      end
      plin_q <= fin.lin;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
    end else if (adv) begin
      pv_q <= vd_q[DIV_IDX];
    end
  end

  // Rounding, scaling back to Q2.14 and saturation.
  logic signed [COMP_W-1:0] comp [4];
  res_t                     res;

  always_comb begin
    logic signed [SUM_W-1:0] sum;
    logic signed [RND_W-1:0] rnd;
    for (int i = 0; i < 4; i++) begin
      sum = SUM_W'(pr0_q[i]) + SUM_W'(pr1_q[i]) + (SUM_W'(1) << (ANG_BITS - 1));
      rnd = sum[SUM_W-1:ANG_BITS];
      if (rnd > RND_W'(32767)) begin
        comp[i] = 16'sd32767;
      end else if (rnd < -RND_W'(32768)) begin
        comp[i] = -16'sd32768;
      end else begin
        comp[i] = rnd[COMP_W-1:0];
      end
    end
    res.out_x       = comp[0];
    res.out_y       = comp[1];
    res.out_z       = comp[2];
    res.out_w       = comp[3];
    res.used_linear = plin_q;
  end

  // Output register and skid stage.
  res_t out_q, skid_q;
  logic out_v_q, skid_v_q, out_take;

  assign adv      = ~skid_v_q;
  assign out_take = ~out_v_q | out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (out_take) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end
    end else if (pv_q) begin
      if (out_take) begin
        out_v_q <= 1'b1;
      end else begin
        skid_v_q <= 1'b1;
      end
    end else if (out_take) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (out_take) begin
        out_q <= skid_q;
      end
    end else if (pv_q) begin
      if (out_take) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end
  end

  assign out_o.valid       = out_v_q;
  assign out_o.out_x       = out_q.out_x;
  assign out_o.out_y       = out_q.out_y;
  assign out_o.out_z       = out_q.out_z;
  assign out_o.out_w       = out_q.out_w;
  assign out_o.used_linear = out_q.used_linear;

  // Checks on the skid stage and the divisor.
  `QS_ASSERT_NR(a_skid_has_out, clk_i, skid_v_q |-> out_v_q, "skid full with output empty")
  `QS_ASSERT(a_skid_fill, clk_i, rst_ni, $rose(skid_v_q) |-> $past(pv_q && out_v_q && !out_o.ready), "skid filled without a stalled output")
  `QS_ASSERT(a_root_nonzero, clk_i, rst_ni, (vd_q[S_IDX] && !sd_q[S_IDX].lin) |-> (root != '0), "zero sine reached the divider")

endmodule

>>> sv/qslerp_isqrt.sv
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Floor square root, one result bit per stage, one operand per cycle while en_i is high.
// ----------------------------------------------------------------------------
module qslerp_isqrt (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [qslerp_pkg::RAD_W-1:0]  rad_i,
  output logic [qslerp_pkg::ROOT_W-1:0] root_o
);
  import qslerp_pkg::*;

  localparam int unsigned TW = RAD_W + 1;

  logic [RAD_W-1:0]  rem_q  [ROOT_W-1];
  logic [ROOT_W-1:0] root_q [ROOT_W];

  for (genvar j = 0; j < ROOT_W; j++) begin : g_stage
    localparam int unsigned K = ROOT_W - 1 - j;
    logic [RAD_W-1:0]  rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [TW-1:0]     term;
    logic              ge;

    if (j == 0) begin : g_first
      assign rem_in  = rad_i;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_q[j-1];
      assign root_in = root_q[j-1];
    end

    // Growth of the square when bit K joins the root: 2*R*2^K + 2^(2K).
    assign term = (TW'(root_in) << (K + 1)) | (TW'(1) << (2 * K));
    assign ge   = {1'b0, rem_in} >= term;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        root_q[j] <= root_in | (ROOT_W'(ge) << K);
      end
    end

    if (j < ROOT_W - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[j] <= ge ? (rem_in - term[RAD_W-1:0]) : rem_in;
        end
      end
    end
  end

  assign root_o = root_q[ROOT_W-1];

endmodule

>>> sv/qslerp_cordic.sv
// ----------------------------------------------------------------------------
// Pipelined CORDIC
// One micro-rotation per stage, in vectoring or rotation mode.
// ----------------------------------------------------------------------------
module qslerp_cordic #(
  parameter bit VECTORING = 1'b1
) (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic signed [qslerp_pkg::XW-1:0]    x_i,
  input  logic signed [qslerp_pkg::XW-1:0]    y_i,
  input  logic signed [qslerp_pkg::ZW-1:0]    z_i,
  output logic signed [qslerp_pkg::XW-1:0]    y_o,
  output logic signed [qslerp_pkg::ZW-1:0]    z_o
);
  import qslerp_pkg::*;

  logic signed [XW-1:0] x_q [CORDIC_STEPS-1];
  logic signed [XW-1:0] y_q [CORDIC_STEPS];
  logic signed [ZW-1:0] z_q [CORDIC_STEPS];

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    logic signed [XW-1:0] x_in, y_in, dx, dy;
    logic signed [ZW-1:0] z_in, da;
    logic                 up;

    if (i == 0) begin : g_first
      assign x_in = x_i;
      assign y_in = y_i;
      assign z_in = z_i;
    end else begin : g_next
      assign x_in = x_q[i-1];
      assign y_in = y_q[i-1];
      assign z_in = z_q[i-1];
    end

    assign dx = y_in >>> i;
    assign dy = x_in >>> i;
    assign da = $signed({1'b0, atan_q30(i)});

    // Vectoring drives y toward zero, rotation drives z toward zero.
    if (VECTORING) begin : g_vec
      assign up = ~y_in[XW-1];
    end else begin : g_rot
      assign up = ~z_in[ZW-1];
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (VECTORING) begin
          y_q[i] <= up ? (y_in - dy) : (y_in + dy);
          z_q[i] <= up ? (z_in + da) : (z_in - da);
        end else begin
          y_q[i] <= up ? (y_in + dy) : (y_in - dy);
          z_q[i] <= up ? (z_in - da) : (z_in + da);
        end
      end
    end

    if (i < CORDIC_STEPS - 1) begin : g_x
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          if (VECTORING == up) begin
            x_q[i] <= x_in + dx;
          end else begin
            x_q[i] <= x_in - dx;
          end
        end
      end
    end
  end

  assign y_o = y_q[CORDIC_STEPS-1];
  assign z_o = z_q[CORDIC_STEPS-1];

endmodule

>>> sv/qslerp_div.sv
// ----------------------------------------------------------------------------
// Pipelined weight divider
// Computes (sn * 2^30) / s truncated toward zero, clamped to +/-2^31.
// One quotient bit per stage plus a final sign and clamp stage.
// ----------------------------------------------------------------------------
module qslerp_div (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic signed [qslerp_pkg::SW-1:0]  sn_i,
  input  logic [qslerp_pkg::ROOT_W-1:0]     s_i,
  output logic signed [qslerp_pkg::SW-1:0]  wq_o
);
  import qslerp_pkg::*;

  logic [NUM_W-1:0]     rem_q [DIV_QBITS-1];
  logic [ROOT_W-1:0]    s_q   [DIV_QBITS-1];
  logic [DIV_QBITS-1:0] q_q   [DIV_QBITS];
  logic                 neg_q [DIV_QBITS];
  logic                 ovf_q [DIV_QBITS];
  logic signed [SW-1:0] wq_q;

  // Operand preparation: magnitude and a check for a quotient of 2^32 or more.
  logic              neg0, ovf0;
  logic [SW-1:0]     mag0;
  logic [NUM_W-1:0]  num0;

  assign neg0 = sn_i[SW-1];
  assign mag0 = neg0 ? SW'(-sn_i) : SW'(sn_i);
  assign num0 = {mag0, {ANG_BITS{1'b0}}};
  assign ovf0 = (mag0 >> 2) >= SW'(s_i);

  for (genvar j = 0; j < DIV_QBITS; j++) begin : g_stage
    localparam int unsigned K = DIV_QBITS - 1 - j;
    logic [NUM_W-1:0]     rem_in, cand;
    logic [ROOT_W-1:0]    s_in;
    logic [DIV_QBITS-1:0] q_in;
    logic                 neg_in, ovf_in, ge;

    if (j == 0) begin : g_first
      assign rem_in = num0;
      assign s_in   = s_i;
      assign q_in   = '0;
      assign neg_in = neg0;
      assign ovf_in = ovf0;
    end else begin : g_next
      assign rem_in = rem_q[j-1];
      assign s_in   = s_q[j-1];
      assign q_in   = q_q[j-1];
      assign neg_in = neg_q[j-1];
      assign ovf_in = ovf_q[j-1];
    end

    assign cand = NUM_W'(s_in) << K;
    assign ge   = rem_in >= cand;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        q_q[j]   <= q_in | (DIV_QBITS'(ge) << K);
        neg_q[j] <= neg_in;
        ovf_q[j] <= ovf_in;
      end
    end

    if (j < DIV_QBITS - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[j] <= ge ? (rem_in - cand) : rem_in;
          s_q[j]   <= s_in;
        end
      end
    end
  end

  // Clamp the magnitude and restore the sign.
  localparam logic [SW-1:0] LIM = SW'(1) << (DIV_QBITS - 1);
  logic [SW-1:0] qmag;

  always_comb begin
    qmag = SW'(q_q[DIV_QBITS-1]);
    if (ovf_q[DIV_QBITS-1] || qmag > LIM) begin
      qmag = LIM;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      wq_q <= neg_q[DIV_QBITS-1] ? $signed(-qmag) : $signed(qmag);
    end
  end

  assign wq_o = wq_q;

endmodule

>>> verif/testbench.sv
// ----------------------------------------------------------------------------
// Quaternion slerp testbench
// Drives start/end quaternion pairs with blend factors into the slerp block
// under random source and sink stalls. Every input transfer is run through a
// bit-exact slerp predictor, and each output transfer is checked against the
// oldest predicted result. The threshold register is rewritten between phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import qslerp_pkg::*;

  localparam int unsigned PIPE_DRAIN  = 140;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned CHUNK_ITEMS = 72;
  localparam int          FRAC_BITS_TB = 14;

  // One input item: start quaternion, end quaternion and blend factor.
  typedef struct {
    logic signed [COMP_W-1:0] from_q[4];
    logic signed [COMP_W-1:0] to_q[4];
    logic [BLEND_W-1:0]       blend;
  } quat_pair_t;

  // atan(2^-i) in Q30 radians, truncated.
  localparam longint ARCTAN_Q30[30] = '{
    843314856, 497837829, 263043836, 133525158, 67021686,
    33543515, 16775850, 8388437, 4194282, 2097149,
    1048575, 524287, 262143, 131071, 65535,
    32767, 16383, 8191, 4095, 2047,
    1023, 511, 255, 127, 63,
    31, 15, 7, 3, 1
  };

  logic clk_i;
  logic rst_ni;

  qslerp_in_if  in_ch();
  qslerp_out_if out_ch();
  qslerp_cfg_if cfg_ch();

  quaternion_slerp_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch.sink),
    .out_o  (out_ch.source),
    .cfg_i  (cfg_ch.sink)
  );

  quat_pair_t       pending_pairs[$];
  res_t             expected_slerp[$];
  logic [THR_W-1:0] model_threshold;
  int unsigned      send_idle_pct;
  int unsigned      recv_idle_pct;
  int unsigned      mismatch_count;
  int unsigned      cycle_count;
  logic             in_taken;

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Integer square root, floor.
  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned root;
    longint unsigned bit_val;
    root    = 0;
    bit_val = 64'd1 << 62;
    while (bit_val > v) bit_val >>= 2;
    while (bit_val != 0) begin
      if (v >= root + bit_val) begin
        v    = v - (root + bit_val);
        root = (root >> 1) + bit_val;
      end else begin
        root = root >> 1;
      end
      bit_val >>= 2;
    end
    return root;
  endfunction

  // Angle of the vector (x, y) by vectoring CORDIC, Q30 radians.
  function automatic longint cordic_angle(input longint x, input longint y);
    longint acc_z;
    longint step_x;
    longint step_y;
    acc_z = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      step_x = y >>> i;
      step_y = x >>> i;
      if (y >= 0) begin
        x += step_x; y -= step_y; acc_z += ARCTAN_Q30[i];
      end else begin
        x -= step_x; y += step_y; acc_z -= ARCTAN_Q30[i];
      end
    end
    return acc_z;
  endfunction

  // Sine of a Q30 angle by rotation CORDIC, Q30 result.
  function automatic longint cordic_sine(input longint ang);
    longint x;
    longint y;
    longint step_x;
    longint step_y;
    x = longint'(CORDIC_INV_GAIN);
    y = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      step_x = y >>> i;
      step_y = x >>> i;
      if (ang >= 0) begin
        x -= step_x; y += step_y; ang -= ARCTAN_Q30[i];
      end else begin
        x += step_x; y -= step_y; ang += ARCTAN_Q30[i];
      end
    end
    return y;
  endfunction

  // Weight sin(a)/sin(w) in Q30, truncated toward zero and clamped.
  function automatic longint sine_ratio(input longint sn, input longint sin_w);
    longint lim;
    longint wt;
    lim = 64'sd1 <<< 31;
    wt  = (sn * (64'sd1 <<< ANG_BITS)) / sin_w;
    if (wt > lim) wt = lim;
    if (wt < -lim) wt = -lim;
    return wt;
  endfunction

  // Expected slerp result of one pair under the given threshold.
  function automatic res_t predict_slerp(input quat_pair_t pr, input logic [THR_W-1:0] thr);
    longint          p[4];
    longint          q[4];
    longint          dot;
    longint          wt0;
    longint          wt1;
    longint          ang;
    longint          ang1;
    longint          acc;
    longint unsigned t_eff;
    longint unsigned dabs;
    longint unsigned cosq;
    longint unsigned sin_w;
    logic            linear;
    logic [COMP_W-1:0] comp[4];
    res_t            r;
    t_eff = (pr.blend > BLEND_ONE) ? BLEND_ONE : pr.blend;
    dot   = 0;
    for (int i = 0; i < 4; i++) begin
      p[i] = pr.from_q[i];
      q[i] = pr.to_q[i];
      dot += p[i] * q[i];
    end
    // Take the shorter arc.
    if (dot < 0) begin
      dabs = -dot;
      for (int i = 0; i < 4; i++) p[i] = -p[i];
    end else begin
      dabs = dot;
    end
    linear = (dabs >= (longint'(thr) << FRAC_BITS_TB)) || (dabs >= (64'd1 << 28));
    if (linear) begin
      wt0 = longint'(32768 - t_eff) << 15;
      wt1 = longint'(t_eff) << 15;
    end else begin
      cosq  = dabs << (ANG_BITS - 2 * FRAC_BITS_TB);
      sin_w = int_sqrt((64'd1 << 60) - cosq * cosq);
      ang   = cordic_angle(longint'(cosq), longint'(sin_w));
      if (ang < 0) ang = 0;
      ang1 = (ang * longint'(t_eff)) >>> 15;
      wt0  = sine_ratio(cordic_sine(ang - ang1), longint'(sin_w));
      wt1  = sine_ratio(cordic_sine(ang1), longint'(sin_w));
    end
    // Weighted sum, rounded and saturated.
    for (int i = 0; i < 4; i++) begin
      acc = (wt0 * p[i] + wt1 * q[i] + (64'sd1 <<< (ANG_BITS - 1))) >>> ANG_BITS;
      if (acc > 32767) acc = 32767;
      if (acc < -32768) acc = -32768;
      comp[i] = acc[COMP_W-1:0];
    end
    r.out_x       = comp[0];
    r.out_y       = comp[1];
    r.out_z       = comp[2];
    r.out_w       = comp[3];
    r.used_linear = linear;
    return r;
  endfunction

  function automatic quat_pair_t make_pair(input int fx, fy, fz, fw, tx, ty, tz, tw,
                                           input int t);
    quat_pair_t pr;
    pr.from_q = '{fx[15:0], fy[15:0], fz[15:0], fw[15:0]};
    pr.to_q   = '{tx[15:0], ty[15:0], tz[15:0], tw[15:0]};
    pr.blend  = t[15:0];
    return pr;
  endfunction

  // Random pair: mostly unit-scale quaternions, many nearly coinciding or
  // opposed, plus raw noise over the full field range.
  function automatic quat_pair_t random_pair();
    quat_pair_t  pr;
    int unsigned kind;
    int unsigned tsel;
    int          v;
    kind = $urandom_range(99);
    for (int i = 0; i < 4; i++) begin
      if (kind < 15) begin
        pr.from_q[i] = 16'($urandom);
        pr.to_q[i]   = 16'($urandom);
      end else begin
        v            = int'($urandom_range(16384)) - 8192;
        pr.from_q[i] = v[15:0];
        if (kind < 50) v = v + int'($urandom_range(120)) - 60;
        else v = int'($urandom_range(16384)) - 8192;
        if (kind >= 35 && kind < 50) v = -v;
        pr.to_q[i] = v[15:0];
      end
    end
    tsel = $urandom_range(99);
    if (tsel < 10) pr.blend = 16'($urandom_range(65535, 32769));
    else if (tsel < 14) pr.blend = '0;
    else if (tsel < 18) pr.blend = BLEND_ONE;
    else pr.blend = 16'($urandom_range(32768));
    return pr;
  endfunction

  // Compare one field of a result transfer.
  task automatic check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("Mismatch on %s at %0t: expected %0d, got %0d", name, $realtime, exp_v,
                 act_v);
    end
  endtask

  // Input driver: holds an item until its transfer, otherwise idles at random.
  always @(negedge clk_i) begin
    logic       drive_valid;
    quat_pair_t head;
    drive_valid = 1'b0;
    if (rst_ni && pending_pairs.size() != 0) begin
      if ((in_ch.valid && !in_taken) || $urandom_range(99) >= send_idle_pct) begin
        drive_valid = 1'b1;
      end
    end
    if (drive_valid) begin
      head = pending_pairs[0];
      in_ch.from_x <= head.from_q[0];
      in_ch.from_y <= head.from_q[1];
      in_ch.from_z <= head.from_q[2];
      in_ch.from_w <= head.from_q[3];
      in_ch.to_x   <= head.to_q[0];
      in_ch.to_y   <= head.to_q[1];
      in_ch.to_z   <= head.to_q[2];
      in_ch.to_w   <= head.to_q[3];
      in_ch.blend  <= head.blend;
    end
    in_ch.valid  <= drive_valid;
    out_ch.ready <= rst_ni && ($urandom_range(99) >= recv_idle_pct);
  end

  // Monitor: predicts on input transfers and checks output transfers.
  always @(posedge clk_i) begin
    res_t got;
    res_t exp_r;
    in_taken = in_ch.valid && in_ch.ready;
    if (in_taken) begin
      expected_slerp.push_back(predict_slerp(pending_pairs[0], model_threshold));
      void'(pending_pairs.pop_front());
    end
    if (out_ch.valid && out_ch.ready) begin
      got.out_x       = out_ch.out_x;
      got.out_y       = out_ch.out_y;
      got.out_z       = out_ch.out_z;
      got.out_w       = out_ch.out_w;
      got.used_linear = out_ch.used_linear;
      if (expected_slerp.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("Unexpected result transfer at %0t", $realtime);
      end else begin
        exp_r = expected_slerp.pop_front();
        check_field("out_x", $signed(exp_r.out_x), $signed(got.out_x));
        check_field("out_y", $signed(exp_r.out_y), $signed(got.out_y));
        check_field("out_z", $signed(exp_r.out_z), $signed(got.out_z));
        check_field("out_w", $signed(exp_r.out_w), $signed(got.out_w));
        check_field("used_linear", exp_r.used_linear, got.used_linear);
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Threshold register write through its own channel.
  task automatic write_threshold(input logic [THR_W-1:0] value);
    @(negedge clk_i);
    cfg_ch.valid            <= 1'b1;
    cfg_ch.linear_threshold <= value;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    model_threshold = value;
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  // Wait until every queued item has been sent and every result checked.
  task automatic drain_pipeline();
    while (pending_pairs.size() != 0 || expected_slerp.size() != 0) @(posedge clk_i);
    repeat (PIPE_DRAIN) @(posedge clk_i);
  endtask

  // Stimulus sequence.
  initial begin
    logic [THR_W-1:0] thr_list[6];
    cycle_count             = 0;
    mismatch_count          = 0;
    in_taken                = 1'b0;
    model_threshold         = THR_RESET;
    send_idle_pct           = 33;
    recv_idle_pct           = 87;
    rst_ni                  = 1'b0;
    in_ch.valid             = 1'b0;
    in_ch.from_x            = '0;
    in_ch.from_y            = '0;
    in_ch.from_z            = '0;
    in_ch.from_w            = '0;
    in_ch.to_x              = '0;
    in_ch.to_y              = '0;
    in_ch.to_z              = '0;
    in_ch.to_w              = '0;
    in_ch.blend             = '0;
    out_ch.ready            = 1'b0;
    cfg_ch.valid            = 1'b0;
    cfg_ch.linear_threshold = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed pairs under the reset threshold.
    pending_pairs.push_back(make_pair(0, 0, 0, 16384, 0, 0, 0, 16384, 16384));
    pending_pairs.push_back(make_pair(0, 0, 0, 16384, 16384, 0, 0, 0, 0));
    pending_pairs.push_back(make_pair(0, 0, 0, 16384, 16384, 0, 0, 0, 32768));
    pending_pairs.push_back(make_pair(0, 0, 0, 16384, 16384, 0, 0, 0, 65535));
    pending_pairs.push_back(make_pair(0, 0, 0, 16384, 11585, 0, 0, 11585, 16384));
    pending_pairs.push_back(make_pair(0, 0, 0, 16384, 0, 0, 0, -16384, 8192));
    pending_pairs.push_back(make_pair(0, 0, 0, 16384, 0, 100, 0, -16383, 24576));
    pending_pairs.push_back(make_pair(-32768, -32768, -32768, -32768,
                                      32767, 32767, 32767, 32767, 16384));
    pending_pairs.push_back(make_pair(-32768, 0, 0, 0, 100, 0, 0, 0, 0));
    pending_pairs.push_back(make_pair(32767, 32767, 32767, 32767,
                                      32767, 32767, 32767, 32767, 32768));
    pending_pairs.push_back(make_pair(-32768, -32768, -32768, -32768,
                                      -32768, -32768, -32768, -32768, 1));
    pending_pairs.push_back(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 16384));
    pending_pairs.push_back(make_pair(0, 0, 0, 16384, 0, 0, 0, 0, 32767));
    pending_pairs.push_back(make_pair(0, 0, 724, 16368, 0, 0, 0, 16384, 16384));
    pending_pairs.push_back(make_pair(0, 0, 700, 16369, 0, 0, 0, 16384, 16384));
    pending_pairs.push_back(make_pair(8192, 8192, 8192, 8192,
                                      -8192, 8192, -8192, 8192, 40000));
    pending_pairs.push_back(make_pair(5000, -6000, 7000, 12000,
                                      -4000, 9000, 3000, 11000, 12345));
    pending_pairs.push_back(make_pair(0, 16384, 0, 0, 0, -16000, 3000, 0, 20000));

    // Random phases over several threshold settings and idling patterns.
    thr_list[0] = THR_RESET;
    thr_list[1] = '0;
    thr_list[2] = 15'd16384;
    thr_list[3] = 15'h7fff;
    thr_list[4] = 15'd15000;
    thr_list[5] = THR_W'($urandom_range(16384, 12000));
    for (int chunk = 0; chunk < 6; chunk++) begin
      if (chunk == 2) begin
        send_idle_pct = 87;
        recv_idle_pct = 33;
      end else if (chunk == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      drain_pipeline();
      write_threshold(thr_list[chunk]);
      for (int n = 0; n < CHUNK_ITEMS; n++) pending_pairs.push_back(random_pair());
    end
    drain_pipeline();

    if (mismatch_count == 0 && expected_slerp.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> quaternion_slerp_top.f
+incdir+sv
sv/qslerp_pkg.sv
sv/qslerp_if.sv
sv/qslerp_isqrt.sv
sv/qslerp_cordic.sv
sv/qslerp_div.sv
sv/quaternion_slerp_top.sv
verif/testbench.sv
